FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define HCH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds across reset
`define HCH_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hdl/hch20_pkg.sv
// types, constants and the quarter round shared by the hchacha20 subkey block
`default_nettype none

package hch20_pkg;

   localparam int WORD_W      = 32;
   localparam int ROUND_COUNT = 20;
   localparam int ROUND_W     = $clog2(ROUND_COUNT);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUND_COUNT - 1);

   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [15:0][WORD_W-1:0] state_type;
   typedef logic [3:0][WORD_W-1:0]  quad_type;

   // "expand 32-byte k"
   localparam word_type SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                      32'h79622d32, 32'h6b206574};

   typedef struct packed {
      logic [63:0] key_part_0;
      logic [63:0] key_part_1;
      logic [63:0] key_part_2;
      logic [63:0] key_part_3;
      logic [63:0] nonce_part_0;
      logic [63:0] nonce_part_1;
   } req_type;

   typedef struct packed {
      logic [63:0] subkey_part_0;
      logic [63:0] subkey_part_1;
      logic [63:0] subkey_part_2;
      logic [63:0] subkey_part_3;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic diag;
      logic capture;
   } cmd_type;

   // one quarter round: element 0 is a, 3 is d
   function automatic quad_type quarter(input word_type a, input word_type b,
                                        input word_type c, input word_type d);
      word_type a1, b1, c1, d1, a2, b2, c2, d2, t;
      quad_type q;
      a1 = a + b;
      t  = d ^ a1;
      d1 = {t[15:0], t[31:16]};
      c1 = c + d1;
      t  = b ^ c1;
      b1 = {t[19:0], t[31:20]};
      a2 = a1 + b1;
      t  = d1 ^ a2;
      d2 = {t[23:0], t[31:24]};
      c2 = c1 + d2;
      t  = b1 ^ c2;
      b2 = {t[24:0], t[31:25]};
      q[0] = a2;
      q[1] = b2;
      q[2] = c2;
      q[3] = d2;
      return q;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/hch20_ctrl.sv
// controller: transaction handshakes and round sequencing
`default_nettype none

module hch20_ctrl
   import hch20_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      valid_in = valid_ff;
      cmd      = '0;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cmd.diag = round_ff[0];
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // output register free, or emptied this cycle
            if (!valid_ff || !rsp_stall) begin
               cmd.capture = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

FILE: hdl/hch20_dp.sv
// datapath: 16-word state, four shared quarter-round units, result register
`default_nettype none

module hch20_dp
   import hch20_pkg::*;
(
   input  wire logic    clock,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   state_type st_ff, st_in;
   state_type init_st, rnd_st;
   rsp_type   rsp_ff, rsp_in;

   // initial state from constants, key and nonce
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         init_st[k] = SIGMA[k];
      end
      init_st[4]  = req_data.key_part_0[31:0];
      init_st[5]  = req_data.key_part_0[63:32];
      init_st[6]  = req_data.key_part_1[31:0];
      init_st[7]  = req_data.key_part_1[63:32];
      init_st[8]  = req_data.key_part_2[31:0];
      init_st[9]  = req_data.key_part_2[63:32];
      init_st[10] = req_data.key_part_3[31:0];
      init_st[11] = req_data.key_part_3[63:32];
      init_st[12] = req_data.nonce_part_0[31:0];
      init_st[13] = req_data.nonce_part_0[63:32];
      init_st[14] = req_data.nonce_part_1[31:0];
      init_st[15] = req_data.nonce_part_1[63:32];
   end

   // one column or diagonal round, four independent quarter rounds
   always_comb begin
      quad_type q;
      word_type b_w, c_w, d_w;
      rnd_st = st_ff;
      for (int i = 0; i < 4; i++) begin
         b_w = cmd.diag ? st_ff[4 + ((i + 1) & 3)]  : st_ff[4 + i];
         c_w = cmd.diag ? st_ff[8 + ((i + 2) & 3)]  : st_ff[8 + i];
         d_w = cmd.diag ? st_ff[12 + ((i + 3) & 3)] : st_ff[12 + i];
         q = quarter(st_ff[i], b_w, c_w, d_w);
         rnd_st[i] = q[0];
         if (cmd.diag) begin
            rnd_st[4 + ((i + 1) & 3)]  = q[1];
            rnd_st[8 + ((i + 2) & 3)]  = q[2];
            rnd_st[12 + ((i + 3) & 3)] = q[3];
         end else begin
            rnd_st[4 + i]  = q[1];
            rnd_st[8 + i]  = q[2];
            rnd_st[12 + i] = q[3];
         end
      end
   end

   always_comb begin
      if (cmd.load) begin
         st_in = init_st;
      end else if (cmd.step) begin
         st_in = rnd_st;
      end else begin
         st_in = st_ff;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.capture) begin
         rsp_in.subkey_part_0 = {st_ff[1], st_ff[0]};
         rsp_in.subkey_part_1 = {st_ff[3], st_ff[2]};
         rsp_in.subkey_part_2 = {st_ff[13], st_ff[12]};
         rsp_in.subkey_part_3 = {st_ff[15], st_ff[14]};
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/hchacha20_subkey_derive.sv
// top level of the hchacha20 subkey derivation block
`default_nettype none

// hchacha20 subkey derivation. a request transaction carries a 256-bit key
// and a 128-bit nonce as little-endian 64-bit parts; the block builds the
// 16-word chacha state (sigma constants, key words, nonce words), runs ten
// double rounds and returns words 0-3 and 12-15 as the 256-bit subkey, with
// no feed-forward add. one round (four quarter rounds, column or diagonal)
// is done per cycle in a single set of four quarter-round units. after the
// last round the result register is loaded once it is free, and no new
// request is taken before the current one is through. the block
// works on one transaction at a time and holds req_stall high while busy.
// the result sits in its own register, so the next request can be taken
// while a finished result still waits under rsp_stall. nothing is kept
// between transactions.

module hchacha20_subkey_derive
   import hch20_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // load / round / capture commands from the sequencer
   cmd_type cmd;

   // sequencer: idle, twenty rounds, then wait for the result register
   hch20_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // state words and result register
   hch20_dp u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hdl/hch20_checker.sv
// port-level assertions for the hchacha20 subkey block and their bind
`default_nettype none

`include "assert_macros.svh"

module hch20_checker
   import hch20_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // a stalled request holds
   `HCH_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_data))

   // a stalled result holds
   `HCH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // one transaction at a time: busy right after an accept
   `HCH_ASSERT(a_busy_after_take, clock, reset, req_take |=> req_stall)

   // a result only appears at the end of a busy period
   `HCH_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

   // no result right out of reset
   `HCH_ASSERT_NR(a_reset_clear, clock, reset |=> !rsp_valid)

endmodule

bind hchacha20_subkey_derive hch20_checker u_hch20_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
